// ----- design/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants of the binary min-heap core
// Command codes, the data and count widths, the empty-heap value, and the structs
// that are broadcast to all sorting cells or pass between neighbouring ones.
// ----------------------------------------------------------------------------
package bmh_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 7;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic signed [DATA_W-1:0] EMPTY_MIN = -32'sd1;

	// operation broadcast to every cell in the same cycle
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [DATA_W-1:0] value;
	} bmh_op_t;

	// what a cell shows to its neighbours
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] val;
		logic                     gt;   // pushed value belongs at or before this cell
	} bmh_link_t;

endpackage

// ----- design/bmh_cell.sv -----
// ----------------------------------------------------------------------------
// bmh_cell: one slot of the sorted cell chain
// Holds one value. On a push it keeps its value, takes the pushed value or
// takes its left neighbour's value; on a pop it takes its right neighbour's.
// ----------------------------------------------------------------------------
module bmh_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bmh_pkg::bmh_op_t    op,
	input  bmh_pkg::bmh_link_t  left,
	input  bmh_pkg::bmh_link_t  right,
	output bmh_pkg::bmh_link_t  self
);

	logic                              vld_q;
	logic signed [bmh_pkg::DATA_W-1:0] val_q;
	logic                              gt;
	logic                              vld_d;
	logic signed [bmh_pkg::DATA_W-1:0] val_d;

	// the chain is sorted and packed to the left, so gt rises once along it
	assign gt = !vld_q || (op.value < val_q);

	always_comb begin
		vld_d = vld_q;
		val_d = val_q;
		if (op.push) begin
			if (left.gt) begin
				vld_d = left.vld;
				val_d = left.val;
			end else if (gt) begin
				vld_d = 1'b1;
				val_d = op.value;
			end
		end else if (op.pop) begin
			vld_d = right.vld;
			val_d = right.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign self.vld = vld_q;
	assign self.val = val_q;
	assign self.gt  = gt;

endmodule

// ----- design/binary_min_heap_core.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_core: min-priority queue of signed 32-bit values
// The result of an item is registered when the item is taken and is valid in the next cycle.
// Throughput: one item per cycle while in_stall is low; every cell of the chain shifts in parallel.
// Input stall is raised only while an unread result is held and out_stall is high.
// Reset: the cells' valid bits and the internal fill count clear at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_min_heap_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic signed [bmh_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bmh_pkg::DATA_W-1:0] min_value,
	output logic [bmh_pkg::COUNT_W-1:0]       entry_count,
	output logic                              is_empty,
	output logic                              overflow
);

	localparam int unsigned FillW = $clog2(CAPACITY + 1);

	bmh_pkg::bmh_link_t links [0:CAPACITY+1];
	bmh_pkg::bmh_op_t   op;

	logic             accept;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic             drop;
	logic [FillW-1:0] fill_q;
	logic [FillW-1:0] fill_d;
	logic signed [bmh_pkg::DATA_W-1:0] min_d;

	logic                              out_valid_q;
	logic signed [bmh_pkg::DATA_W-1:0] min_value_q;
	logic [bmh_pkg::COUNT_W-1:0]       entry_count_q;
	logic                              is_empty_q;
	logic                              overflow_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full  = (fill_q == FillW'(CAPACITY));
	assign empty = (fill_q == '0);

	assign do_push = accept && (command == bmh_pkg::CMD_PUSH) && !full;
	assign do_pop  = accept && (command == bmh_pkg::CMD_POP) && !empty;
	assign drop    = accept && (command == bmh_pkg::CMD_PUSH) && full;

	assign op.push  = do_push;
	assign op.pop   = do_pop;
	assign op.value = push_value;

	// chain ends: nothing enters from the left, empty slot from the right
	assign links[0]          = '0;
	assign links[CAPACITY+1] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bmh_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (links[i]),
			.right  (links[i+2]),
			.self   (links[i+1])
		);
	end

	// count and head of the chain after this item
	always_comb begin
		fill_d = fill_q;
		min_d  = links[1].val;
		if (do_push) begin
			fill_d = fill_q + FillW'(1);
			if (links[1].gt) begin
				min_d = push_value;
			end
		end else if (do_pop) begin
			fill_d = fill_q - FillW'(1);
			min_d  = links[2].val;
		end
		if (fill_d == '0) begin
			min_d = bmh_pkg::EMPTY_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			min_value_q   <= min_d;
			entry_count_q <= bmh_pkg::COUNT_W'(fill_d);
			is_empty_q    <= (fill_d == '0);
			overflow_q    <= drop;
		end
	end

	assign out_valid   = out_valid_q;
	assign min_value   = min_value_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;
	assign overflow    = overflow_q;

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		links[1].vld == (fill_q != '0))
		else $error("head cell valid disagrees with entry count");

	a_tail_matches_full: assert property (@(posedge clk) disable iff (!arst_n)
		links[CAPACITY].vld == full)
		else $error("last cell valid disagrees with full flag");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		links[2].vld |-> (links[1].vld && links[1].val <= links[2].val))
		else $error("chain head out of order");

	a_drop_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		drop |=> (out_valid_q && overflow_q && $stable(fill_q)))
		else $error("dropped push not flagged or count changed");

endmodule

// ----- verif/binary_min_heap_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_checker: result scoreboard for the min-heap core
// Keeps a shadow heap that is updated on every accepted item and works out the
// result that the item should give. Every accepted result is compared in order
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module binary_min_heap_checker #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              command,
	input  logic signed [bmh_pkg::DATA_W-1:0] push_value,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [bmh_pkg::DATA_W-1:0] min_value,
	input  logic [bmh_pkg::COUNT_W-1:0]       entry_count,
	input  logic                              is_empty,
	input  logic                              overflow,
	output int                                mismatches,
	output int                                outstanding
);

	typedef struct packed {
		logic signed [bmh_pkg::DATA_W-1:0] min_value;
		logic [bmh_pkg::COUNT_W-1:0]       entry_count;
		logic                              is_empty;
		logic                              overflow;
	} heap_status_t;

	logic signed [bmh_pkg::DATA_W-1:0] shadow_heap [CAPACITY];
	int unsigned                       shadow_fill;
	heap_status_t                      pending_status [$];

	function automatic void swap_entries(input int unsigned a, input int unsigned b);
		logic signed [bmh_pkg::DATA_W-1:0] tmp;
		tmp            = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = tmp;
	endfunction

	// apply one push or pop to the shadow heap and return the status it leaves
	function automatic heap_status_t apply_heap_op(input logic cmd,
			input logic signed [bmh_pkg::DATA_W-1:0] value);
		heap_status_t status;
		int unsigned  pos;
		int unsigned  parent;
		int unsigned  left;
		int unsigned  right;
		int unsigned  best;
		logic         settled;
		status.overflow = 1'b0;
		if (cmd == bmh_pkg::CMD_PUSH) begin
			if (shadow_fill >= CAPACITY) begin
				status.overflow = 1'b1;
			end else begin
				pos              = shadow_fill;
				shadow_heap[pos] = value;
				while (pos > 0 && shadow_heap[(pos - 1) / 2] > shadow_heap[pos]) begin
					parent = (pos - 1) / 2;
					swap_entries(parent, pos);
					pos = parent;
				end
				shadow_fill++;
			end
		end else if (shadow_fill > 0) begin
			shadow_fill--;
			if (shadow_fill > 0) begin
				shadow_heap[0] = shadow_heap[shadow_fill];
				pos            = 0;
				settled        = 1'b0;
				// on equal children the left one wins
				while (!settled) begin
					left  = 2 * pos + 1;
					right = left + 1;
					best  = pos;
					if (left < shadow_fill && shadow_heap[best] > shadow_heap[left])
						best = left;
					if (right < shadow_fill && shadow_heap[best] > shadow_heap[right])
						best = right;
					if (best == pos) begin
						settled = 1'b1;
					end else begin
						swap_entries(best, pos);
						pos = best;
					end
				end
			end
		end
		status.min_value   = (shadow_fill > 0) ? shadow_heap[0] : bmh_pkg::EMPTY_MIN;
		status.entry_count = shadow_fill[bmh_pkg::COUNT_W-1:0];
		status.is_empty    = (shadow_fill == 0);
		return status;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_status_t want;
		heap_status_t seen;
		if (!arst_n) begin
			pending_status.delete();
			shadow_fill = 0;
			outstanding = 0;
			mismatches  = 0;
		end else begin
			if (in_valid && !in_stall)
				pending_status.push_back(apply_heap_op(command, push_value));
			if (out_valid && !out_stall) begin
				seen = {min_value, entry_count, is_empty, overflow};
				if (pending_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing pending: min %0d count %0d empty %0b ovf %0b",
							$realtime, seen.min_value, seen.entry_count, seen.is_empty,
							seen.overflow);
				end else begin
					want = pending_status.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected min %0d count %0d empty %0b ovf %0b",
								want.min_value, want.entry_count, want.is_empty, want.overflow);
							$display("  actual   min %0d count %0d empty %0b ovf %0b",
								seen.min_value, seen.entry_count, seen.is_empty, seen.overflow);
						end
					end
				end
			end
			outstanding = pending_status.size();
		end
	end

endmodule

// ----- verif/binary_min_heap_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_core_tb: regression bench for the min-heap core
// Drives a directed set of pushes and pops followed by phases of random
// traffic that fill, drain and churn the heap, with random gaps on the input
// and random stalls on the output. The checker beside the core scores results.
// ----------------------------------------------------------------------------
module binary_min_heap_core_tb;

	localparam int unsigned CAPACITY    = 64;
	localparam int          ITEM_TARGET = 800;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          TAIL_CYCLES = 8;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic                              command;
	logic signed [bmh_pkg::DATA_W-1:0] push_value;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [bmh_pkg::DATA_W-1:0] min_value;
	logic [bmh_pkg::COUNT_W-1:0]       entry_count;
	logic                              is_empty;
	logic                              overflow;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int rx_hold;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	always #5 clk = ~clk;

	binary_min_heap_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.min_value(min_value),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.overflow(overflow)
	);

	binary_min_heap_checker #(
		.CAPACITY(CAPACITY)
	) heap_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.min_value(min_value),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.overflow(overflow),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// result side: after each item taken, hold off for a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold   <= 0;
		end else if (out_valid && !out_stall) begin
			draw = rx_quiet ? 0 : $urandom_range(0, 5);
			out_stall <= (draw != 0);
			rx_hold   <= draw;
		end else if (rx_hold != 0) begin
			out_stall <= (rx_hold > 1);
			rx_hold   <= rx_hold - 1;
		end
	end

	// mostly wide random words, with clusters of small values for ties and some extremes
	function automatic logic signed [bmh_pkg::DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			5, 6, 7: begin
				return $signed($urandom_range(0, 8)) - 4;
			end
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_item(input logic cmd,
			input logic signed [bmh_pkg::DATA_W-1:0] value);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		push_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int  items;
		int  len;
		int  pop_pct;
		int  kind;
		bit  first;
		in_valid   = 1'b0;
		command    = bmh_pkg::CMD_PUSH;
		push_value = '0;
		arst_n     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty heap, then extremes in and out in order
		send_item(bmh_pkg::CMD_POP, 32'sh7fff_ffff);
		send_item(bmh_pkg::CMD_POP, 32'sh8000_0000);
		send_item(bmh_pkg::CMD_PUSH, 32'sd0);
		send_item(bmh_pkg::CMD_PUSH, 32'sh7fff_ffff);
		send_item(bmh_pkg::CMD_PUSH, 32'sh8000_0000);
		send_item(bmh_pkg::CMD_PUSH, -32'sd1);
		send_item(bmh_pkg::CMD_PUSH, 32'sd1);
		send_item(bmh_pkg::CMD_PUSH, -32'sd1);
		repeat (6) send_item(bmh_pkg::CMD_POP, $urandom);
		send_item(bmh_pkg::CMD_POP, -32'sd1);
		send_item(bmh_pkg::CMD_PUSH, 32'sh7fff_ffff);
		send_item(bmh_pkg::CMD_POP, 32'sd0);
		send_item(bmh_pkg::CMD_PUSH, 32'sh8000_0000);
		send_item(bmh_pkg::CMD_PUSH, 32'sh8000_0000);
		send_item(bmh_pkg::CMD_PUSH, 32'sd5);
		send_item(bmh_pkg::CMD_POP, 32'sd0);
		send_item(bmh_pkg::CMD_POP, 32'sd0);
		send_item(bmh_pkg::CMD_POP, 32'sd0);

		// first phase pushes past capacity so the full case is always hit
		items = 0;
		first = 1'b1;
		while (items < ITEM_TARGET) begin
			kind = first ? 0 : $urandom_range(0, 2);
			case (kind)
				0: pop_pct = first ? 0 : 10;
				1: pop_pct = 85;
				default: pop_pct = 50;
			endcase
			len      = first ? 80 : $urandom_range(10, 100);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				send_item(($urandom_range(0, 99) < pop_pct) ? bmh_pkg::CMD_POP
					: bmh_pkg::CMD_PUSH, pick_value());
				items++;
			end
			// let the core run dry now and then
			if (first || $urandom_range(0, 3) == 0)
				wait_results();
			first = 1'b0;
		end

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
